// ----- sv/nfa_wa_pkg.sv -----
// shared constants and types of the nfa word acceptor
package nfa_wa_pkg;

    // automaton dimensions
    localparam int NUM_STATES      = 16;
    localparam int MAX_TRANSITIONS = 64;
    localparam int SYMBOL_BITS     = 8;

    // port field widths
    localparam int IDX_W   = $clog2(MAX_TRANSITIONS);
    localparam int STATE_W = 4;
    localparam int SYM_W   = 8;
    localparam int FINAL_W = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_INITIAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK    = 2'd2;
    localparam int CFG_DATA_W = 16;

    // one stored transition, the valid flag lives in flip-flops
    typedef struct packed {
        logic                   lambda;
        logic [STATE_W-1:0]     src;
        logic [STATE_W-1:0]     dst;
        logic [SYMBOL_BITS-1:0] sym;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/nfa_wa_ram.sv -----
// generic single write port ram with registered read
module nfa_wa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/nfa_word_acceptor_core.sv -----
// top level of the nfa word acceptor: table, active set and scan sequencer
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+--------------------------
//  input   | s_valid s_ready s_kind .. s_empty_word  | s_valid & s_ready
//  result  | m_valid m_ready m_accepted m_no_active.. | m_valid & m_ready
//  config  | cfg_valid cfg_ready cfg_index cfg_data  | cfg_valid & cfg_ready
//
// a table write does not leave the idle state, so the core stays ready for the next item.
// a word item runs table scans through one entry compare unit, one entry a cycle
// over the single ram read port: a symbol needs one move scan plus 1 to NUM_STATES
// closure scans, a first symbol adds the closure of the start state.
// reset clears the entry valid bits at once, no clearing pass is needed.
// a result waiting on m_ready stalls only a following report, which holds s_ready low.
module nfa_word_acceptor_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [nfa_wa_pkg::IDX_W-1:0]        s_entry_index,
    input  logic [nfa_wa_pkg::STATE_W-1:0]      s_from_state,
    input  logic [nfa_wa_pkg::STATE_W-1:0]      s_to_state,
    input  logic [nfa_wa_pkg::SYM_W-1:0]        s_symbol,
    input  logic                                s_entry_is_lambda,
    input  logic                                s_entry_valid,
    input  logic                                s_first_symbol,
    input  logic                                s_last_symbol,
    input  logic                                s_empty_word,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_accepted,
    output logic                                m_no_active_state,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nfa_wa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nfa_wa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NS   = nfa_wa_pkg::NUM_STATES;
    localparam int MT   = nfa_wa_pkg::MAX_TRANSITIONS;
    localparam int IW   = nfa_wa_pkg::IDX_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CLOSE  = 2'd1;
    localparam logic [1:0] ST_MOVE   = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    logic [1:0]                            state_reg, state_next;
    logic [IW:0]                           cnt_reg, cnt_next;
    logic                                  rd_vld_reg, rd_vld_next;
    logic                                  ent_valid_reg;
    logic [NS-1:0]                         set_reg, set_next;
    logic [NS-1:0]                         acc_reg, acc_next;
    logic                                  changed_reg, changed_next;
    logic                                  move_pend_reg, move_pend_next;
    logic                                  report_pend_reg, report_pend_next;
    logic [nfa_wa_pkg::SYMBOL_BITS-1:0]    sym_reg, sym_next;
    logic [MT-1:0]                         valid_reg;
    logic [nfa_wa_pkg::STATE_W-1:0]        init_state_reg;
    logic                                  has_init_reg;
    logic [nfa_wa_pkg::FINAL_W-1:0]        final_mask_reg;
    logic                                  m_valid_reg, m_valid_next;
    logic                                  m_accepted_reg, m_accepted_next;
    logic                                  m_none_reg, m_none_next;

    logic                                  in_xfer;
    logic                                  tbl_we;
    logic                                  wr_in_range;
    nfa_wa_pkg::entry_t                    wr_entry;
    nfa_wa_pkg::entry_t                    ent;
    logic [nfa_wa_pkg::ENTRY_W-1:0]        rd_data;
    logic [IW-1:0]                         rd_addr;
    logic                                  scanning;
    logic                                  scan_end;
    logic [NS-1:0]                         dst_hot;
    logic                                  fires;
    logic                                  lam_hit;
    logic                                  sym_hit;
    logic [NS-1:0]                         set_upd;
    logic [NS-1:0]                         acc_upd;
    logic                                  changed_upd;
    logic [NS-1:0]                         start_set;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_valid && s_ready;

    // table write path
    assign wr_in_range     = ({1'b0, s_entry_index} < (IW + 1)'(MT));
    assign tbl_we          = in_xfer && !s_kind && wr_in_range;
    assign wr_entry.lambda = s_entry_is_lambda;
    assign wr_entry.src    = s_from_state;
    assign wr_entry.dst    = s_to_state;
    assign wr_entry.sym    = s_symbol[nfa_wa_pkg::SYMBOL_BITS-1:0];

    assign rd_addr = cnt_reg[IW-1:0];

    nfa_wa_ram #(
        .WIDTH (nfa_wa_pkg::ENTRY_W),
        .DEPTH (MT)
    ) u_table (
        .aclk    (aclk),
        .we      (tbl_we),
        .wr_addr (s_entry_index),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared entry compare unit
    assign ent      = nfa_wa_pkg::entry_t'(rd_data);
    assign dst_hot  = NS'(1) << ent.dst;
    assign fires    = rd_vld_reg && ent_valid_reg && set_reg[ent.src];
    assign lam_hit  = fires && ent.lambda;
    assign sym_hit  = fires && !ent.lambda && (ent.sym == sym_reg);
    assign set_upd  = set_reg | (lam_hit ? dst_hot : '0);
    assign acc_upd  = acc_reg | (sym_hit ? dst_hot : '0);
    assign changed_upd = changed_reg || (lam_hit && !set_reg[ent.dst]);

    assign scanning = (state_reg == ST_CLOSE) || (state_reg == ST_MOVE);
    assign scan_end = (cnt_reg == (IW + 1)'(MT));

    // start state alone, closed later by a closure scan
    assign start_set = has_init_reg ? (NS'(1) << init_state_reg) : '0;

    // sequencer
    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        rd_vld_next      = 1'b0;
        set_next         = set_reg;
        acc_next         = acc_reg;
        changed_next     = changed_reg;
        move_pend_next   = move_pend_reg;
        report_pend_next = report_pend_reg;
        sym_next         = sym_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_accepted_next  = m_accepted_reg;
        m_none_next      = m_none_reg;

        if (scanning) begin
            cnt_next    = scan_end ? '0 : cnt_reg + 1'b1;
            rd_vld_next = !scan_end;
        end

        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (in_xfer && s_kind) begin
                    sym_next     = s_symbol[nfa_wa_pkg::SYMBOL_BITS-1:0];
                    changed_next = 1'b0;
                    if (s_empty_word) begin
                        set_next         = start_set;
                        move_pend_next   = 1'b0;
                        report_pend_next = 1'b1;
                        state_next       = ST_CLOSE;
                    end else if (s_first_symbol) begin
                        set_next         = start_set;
                        move_pend_next   = 1'b1;
                        report_pend_next = s_last_symbol;
                        state_next       = ST_CLOSE;
                    end else begin
                        acc_next         = '0;
                        move_pend_next   = 1'b0;
                        report_pend_next = s_last_symbol;
                        state_next       = ST_MOVE;
                    end
                end
            end
            ST_CLOSE: begin
                set_next     = set_upd;
                changed_next = changed_upd;
                if (scan_end) begin
                    changed_next = 1'b0;
                    if (changed_upd) begin
                        state_next = ST_CLOSE;
                    end else if (move_pend_reg) begin
                        acc_next       = '0;
                        move_pend_next = 1'b0;
                        state_next     = ST_MOVE;
                    end else if (report_pend_reg) begin
                        state_next = ST_REPORT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MOVE: begin
                acc_next = acc_upd;
                if (scan_end) begin
                    set_next     = acc_upd;
                    changed_next = 1'b0;
                    state_next   = ST_CLOSE;
                end
            end
            ST_REPORT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_accepted_next  = |(set_reg & final_mask_reg);
                    m_none_next      = (set_reg == '0);
                    report_pend_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            rd_vld_reg      <= 1'b0;
            set_reg         <= '0;
            changed_reg     <= 1'b0;
            move_pend_reg   <= 1'b0;
            report_pend_reg <= 1'b0;
            valid_reg       <= '0;
            init_state_reg  <= '0;
            has_init_reg    <= 1'b0;
            final_mask_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            rd_vld_reg      <= rd_vld_next;
            set_reg         <= set_next;
            changed_reg     <= changed_next;
            move_pend_reg   <= move_pend_next;
            report_pend_reg <= report_pend_next;
            m_valid_reg     <= m_valid_next;
            if (tbl_we) begin
                valid_reg[s_entry_index] <= s_entry_valid;
            end
            // configuration transfer
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    nfa_wa_pkg::CFG_INITIAL_STATE: begin
                        init_state_reg <= cfg_data[nfa_wa_pkg::STATE_W-1:0];
                    end
                    nfa_wa_pkg::CFG_HAS_INITIAL: begin
                        has_init_reg <= cfg_data[0];
                    end
                    nfa_wa_pkg::CFG_FINAL_MASK: begin
                        final_mask_reg <= cfg_data[nfa_wa_pkg::FINAL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ent_valid_reg  <= valid_reg[rd_addr];
        acc_reg        <= acc_next;
        sym_reg        <= sym_next;
        m_accepted_reg <= m_accepted_next;
        m_none_reg     <= m_none_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_accepted        = m_accepted_reg;
    assign m_no_active_state = m_none_reg;

endmodule

// ----- sv/nfa_wa_checker.sv -----
// port level checks of the nfa word acceptor and their bind
module nfa_wa_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_kind,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_accepted,
    input logic                                m_no_active_state
);

    // a word item occupies the sequencer for at least one scan
    a_word_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind |=> !s_ready)
        else $error("input still ready after a word item transfer");

    // a table write leaves the input ready for the next item
    a_write_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_kind |=> s_ready)
        else $error("core busy after a table write");

    // an accepting state means the active set is not empty
    a_accept_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> !m_no_active_state)
        else $error("accepted reported with an empty active set");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_accepted)
            && $stable(m_no_active_state))
        else $error("stalled result changed");

endmodule

bind nfa_word_acceptor_core nfa_wa_checker u_nfa_wa_checker (.*);
